>>> rtl/rvx_pkg.sv
// Shared types, constants and helpers for the RV32I integer execute block.
`timescale 1ns / 1ps
`default_nettype none
package rvx_pkg;

  localparam int XLEN      = 32;
  localparam int REG_COUNT = 32;
  localparam int RF_AW     = $clog2(REG_COUNT);

  typedef logic [RF_AW-1:0] rf_addr_t;
  typedef logic [4:0]       reg_idx_t;
  typedef logic [4:0]       mode_t;

  // Register file write port
  typedef struct packed {
    logic           en;
    reg_idx_t       idx;
    logic [XLEN-1:0] val;
  } wb_t;

  localparam mode_t MODE_LUI   = 5'd0;
  localparam mode_t MODE_AUIPC = 5'd1;
  localparam mode_t MODE_JAL   = 5'd2;
  localparam mode_t MODE_JALR  = 5'd3;
  localparam mode_t MODE_BEQ   = 5'd4;
  localparam mode_t MODE_BNE   = 5'd5;
  localparam mode_t MODE_BLT   = 5'd6;
  localparam mode_t MODE_BGE   = 5'd7;
  localparam mode_t MODE_BLTU  = 5'd8;
  localparam mode_t MODE_BGEU  = 5'd9;
  localparam mode_t MODE_ADDI  = 5'd10;
  localparam mode_t MODE_SLTI  = 5'd11;
  localparam mode_t MODE_SLTIU = 5'd12;
  localparam mode_t MODE_XORI  = 5'd13;
  localparam mode_t MODE_ORI   = 5'd14;
  localparam mode_t MODE_ANDI  = 5'd15;
  localparam mode_t MODE_SLLI  = 5'd16;
  localparam mode_t MODE_SRLI  = 5'd17;
  localparam mode_t MODE_SRAI  = 5'd18;
  localparam mode_t MODE_ADD   = 5'd19;
  localparam mode_t MODE_SUB   = 5'd20;
  localparam mode_t MODE_SLL   = 5'd21;
  localparam mode_t MODE_SLT   = 5'd22;
  localparam mode_t MODE_SLTU  = 5'd23;
  localparam mode_t MODE_XOR   = 5'd24;
  localparam mode_t MODE_SRL   = 5'd25;
  localparam mode_t MODE_SRA   = 5'd26;
  localparam mode_t MODE_OR    = 5'd27;
  localparam mode_t MODE_AND   = 5'd28;

  // Register index that names real storage
  function automatic logic idx_ok(reg_idx_t i);
    return 6'(i) < 6'(REG_COUNT);
  endfunction

endpackage
`default_nettype wire

>>> rtl/rvx_regfile.sv
// Register file: two-read one-write synchronous memory with valid bits and write forwarding.
`timescale 1ns / 1ps
`default_nettype none
module rvx_regfile (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                rd_en,
  input  wire rvx_pkg::reg_idx_t   rs1_addr,
  input  wire rvx_pkg::reg_idx_t   rs2_addr,
  input  wire rvx_pkg::wb_t        wb,
  output logic [rvx_pkg::XLEN-1:0] op_a,
  output logic [rvx_pkg::XLEN-1:0] op_b
);
  import rvx_pkg::*;

  logic [XLEN-1:0] mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld_r;

  logic [XLEN-1:0] rdata1_r, rdata2_r;
  logic            rvld1_r, rvld2_r;
  reg_idx_t        ra1_r, ra2_r;

  // last write, for a read that raced it at the same edge
  logic            fwd_en_r;
  reg_idx_t        fwd_idx_r;
  logic [XLEN-1:0] fwd_val_r;

  always_ff @(posedge clk) begin
    if (wb.en) begin
      mem[wb.idx[RF_AW-1:0]] <= wb.val;
    end
    if (rd_en) begin
      rdata1_r <= mem[rs1_addr[RF_AW-1:0]];
      rdata2_r <= mem[rs2_addr[RF_AW-1:0]];
      ra1_r    <= rs1_addr;
      ra2_r    <= rs2_addr;
    end
    if (wb.en) begin
      fwd_idx_r <= wb.idx;
      fwd_val_r <= wb.val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rvld1_r  <= 1'b0;
      rvld2_r  <= 1'b0;
      fwd_en_r <= 1'b0;
    end else begin
      if (wb.en) begin
        vld_r[wb.idx[RF_AW-1:0]] <= 1'b1;
        fwd_en_r                 <= 1'b1;
      end
      if (rd_en) begin
        rvld1_r <= vld_r[rs1_addr[RF_AW-1:0]];
        rvld2_r <= vld_r[rs2_addr[RF_AW-1:0]];
      end
    end
  end

  always_comb begin
    if (!idx_ok(ra1_r)) begin
      op_a = '0;
    end else if (fwd_en_r && fwd_idx_r == ra1_r) begin
      op_a = fwd_val_r;
    end else if (rvld1_r) begin
      op_a = rdata1_r;
    end else begin
      op_a = '0;
    end
    if (!idx_ok(ra2_r)) begin
      op_b = '0;
    end else if (fwd_en_r && fwd_idx_r == ra2_r) begin
      op_b = fwd_val_r;
    end else if (rvld2_r) begin
      op_b = rdata2_r;
    end else begin
      op_b = '0;
    end
  end

endmodule
`default_nettype wire

>>> rtl/rv32i_integer_execute_top.sv
// Top level of the RV32I integer execute block: operand read, execute and result register.
`timescale 1ns / 1ps
`default_nettype none
// Executes one decoded RV32I integer instruction per item and returns one result
// item with the write-back and the next PC. The block takes one item per clock while
// in_stall is low: operands are read from a two-read, one-write synchronous register
// file at the accept edge, the instruction executes from the next cycle on, and when it
// leaves the execute stage the write-back and the load of the output register happen
// at the same edge, so the result is then offered from the output register. The
// result of an item is forwarded to the item right behind it, so back-to-back
// dependent instructions run at full rate. A result held by out_stall stalls the
// input only once the execute stage is also full. Register contents are zero
// after reset with no clearing pass.
module rv32i_integer_execute_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire rvx_pkg::mode_t      in_mode,
  input  wire rvx_pkg::reg_idx_t   in_dest_reg,
  input  wire rvx_pkg::reg_idx_t   in_src1_reg,
  input  wire rvx_pkg::reg_idx_t   in_src2_reg,
  input  wire logic [19:0]         in_raw_immediate,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     out_write_enable,
  output rvx_pkg::reg_idx_t        out_write_index,
  output logic [rvx_pkg::XLEN-1:0] out_write_value,
  output logic                     out_branch_taken,
  output logic [rvx_pkg::XLEN-1:0] out_next_pc
);
  import rvx_pkg::*;

  logic in_acc, s1_fire;

  logic            s1_valid_r, s1_valid_nxt;
  mode_t           s1_mode_r;
  reg_idx_t        s1_rd_r, s1_rs2_r;
  logic [19:0]     s1_raw_r;
  logic [XLEN-1:0] pc_r;

  logic            out_valid_r, out_valid_nxt;
  logic            out_we_r;
  reg_idx_t        out_idx_r;
  logic [XLEN-1:0] out_val_r, out_pc_r;
  logic            out_taken_r;

  logic [XLEN-1:0] op_a, op_b;
  wb_t             wb;

  logic [XLEN-1:0] iimm, uimm, joff, boff, opr2, sum, diff, pc4, pc_off;
  logic [XLEN-1:0] shl, shr, sra, val, next_pc;
  logic [4:0]      shamt;
  logic            lt_s, lt_u, eq, wr, taken, is_imm;

  assign s1_fire  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_fire;
  assign in_acc   = in_valid && !in_stall;

  assign s1_valid_nxt  = in_acc || (s1_valid_r && !s1_fire);
  assign out_valid_nxt = s1_fire || (out_valid_r && out_stall);

  rvx_regfile u_rf (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_acc),
    .rs1_addr (in_src1_reg),
    .rs2_addr (in_src2_reg),
    .wb       (wb),
    .op_a     (op_a),
    .op_b     (op_b)
  );

  // Immediate reassembly
  assign iimm = {{20{s1_raw_r[11]}}, s1_raw_r[11:0]};
  assign uimm = {s1_raw_r, 12'b0};
  assign joff = {{11{s1_raw_r[19]}}, s1_raw_r[19], s1_raw_r[7:0], s1_raw_r[8],
                 s1_raw_r[18:9], 1'b0};
  assign boff = {{19{s1_raw_r[6]}}, s1_raw_r[6], s1_rd_r[0], s1_raw_r[5:0],
                 s1_rd_r[4:1], 1'b0};

  // JALR and the I-type ALU operations take the I immediate; all other modes take rs2
  assign is_imm = (s1_mode_r == MODE_JALR) ||
                  (s1_mode_r >= MODE_ADDI && s1_mode_r <= MODE_SRAI);
  assign opr2   = is_imm ? iimm : op_b;

  assign sum  = op_a + opr2;
  assign diff = op_a - op_b;
  assign eq   = (op_a == opr2);
  assign lt_u = (op_a < opr2);
  assign lt_s = ((op_a ^ 32'h8000_0000) < (opr2 ^ 32'h8000_0000));

  assign shamt = is_imm ? s1_rs2_r : op_b[4:0];
  assign shl   = op_a << shamt;
  assign shr   = op_a >> shamt;
  assign sra   = XLEN'($signed(op_a) >>> shamt);

  assign pc4    = pc_r + 32'd4;
  assign pc_off = pc_r + ((s1_mode_r == MODE_JAL) ? joff : boff);

  always_comb begin
    val     = '0;
    wr      = 1'b0;
    taken   = 1'b0;
    next_pc = pc4;
    case (s1_mode_r)
      MODE_LUI:   begin val = uimm;        wr = 1'b1; end
      MODE_AUIPC: begin val = uimm + pc_r; wr = 1'b1; end
      MODE_JAL: begin
        val = pc4; wr = 1'b1; taken = 1'b1; next_pc = pc_off;
      end
      MODE_JALR: begin
        val = pc4; wr = 1'b1; taken = 1'b1; next_pc = {sum[XLEN-1:1], 1'b0};
      end
      MODE_BEQ:   taken = eq;
      MODE_BNE:   taken = !eq;
      MODE_BLT:   taken = lt_s;
      MODE_BGE:   taken = !lt_s;
      MODE_BLTU:  taken = lt_u;
      MODE_BGEU:  taken = !lt_u;
      MODE_ADDI, MODE_ADD: begin val = sum; wr = 1'b1; end
      MODE_SLTI, MODE_SLT: begin val = {31'b0, lt_s}; wr = 1'b1; end
      MODE_SLTIU, MODE_SLTU: begin val = {31'b0, lt_u}; wr = 1'b1; end
      MODE_XORI, MODE_XOR: begin val = op_a ^ opr2; wr = 1'b1; end
      MODE_ORI, MODE_OR:   begin val = op_a | opr2; wr = 1'b1; end
      MODE_ANDI, MODE_AND: begin val = op_a & opr2; wr = 1'b1; end
      MODE_SLLI, MODE_SLL: begin val = shl; wr = 1'b1; end
      MODE_SRLI, MODE_SRL: begin val = shr; wr = 1'b1; end
      MODE_SRAI, MODE_SRA: begin val = sra; wr = 1'b1; end
      MODE_SUB:   begin val = diff; wr = 1'b1; end
      default:    ;
    endcase
    if (MODE_BEQ <= s1_mode_r && s1_mode_r <= MODE_BGEU && taken) begin
      next_pc = pc_off;
    end
    // x0 and indices past the file drop the write
    if (s1_rd_r == '0 || !idx_ok(s1_rd_r)) begin
      wr = 1'b0;
    end
  end

  assign wb.en  = s1_fire && wr;
  assign wb.idx = s1_rd_r;
  assign wb.val = val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pc_r        <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_fire) begin
        pc_r <= next_pc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mode_r <= in_mode;
      s1_rd_r   <= in_dest_reg;
      s1_rs2_r  <= in_src2_reg;
      s1_raw_r  <= in_raw_immediate;
    end
    if (s1_fire) begin
      out_we_r    <= wr;
      out_idx_r   <= wr ? s1_rd_r : '0;
      out_val_r   <= wr ? val : '0;
      out_taken_r <= taken;
      out_pc_r    <= next_pc;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_write_enable = out_we_r;
  assign out_write_index  = out_idx_r;
  assign out_write_value  = out_val_r;
  assign out_branch_taken = out_taken_r;
  assign out_next_pc      = out_pc_r;

endmodule
`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for the RV32I integer execute block.
`timescale 1ns / 1ps
module tb;
  import rvx_pkg::*;

  localparam mode_t MODE_NOP       = 5'd29;
  localparam mode_t MODE_TOP       = 5'd31;
  localparam int    WATCHDOG_LIMIT = 2000;
  localparam int    DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic            we;
    reg_idx_t        idx;
    logic [XLEN-1:0] val;
    logic            taken;
    logic [XLEN-1:0] npc;
  } retire_t;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_stall;
  mode_t           in_mode;
  reg_idx_t        in_dest_reg;
  reg_idx_t        in_src1_reg;
  reg_idx_t        in_src2_reg;
  logic [19:0]     in_raw_immediate;
  logic            out_valid;
  logic            out_stall;
  logic            out_write_enable;
  reg_idx_t        out_write_index;
  logic [XLEN-1:0] out_write_value;
  logic            out_branch_taken;
  logic [XLEN-1:0] out_next_pc;

  // architectural state of the predictor
  logic [XLEN-1:0] arch_regs [REG_COUNT];
  logic [XLEN-1:0] arch_pc;
  retire_t         expected_retire [$];

  int mismatch_count;
  int insns_issued;
  int results_checked;
  int taken_count;
  int idle_cycles;
  int burst_left;
  bit send_gaps;
  bit stall_on;
  bit stall_state;
  int stall_run;

  rv32i_integer_execute_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_dest_reg      (in_dest_reg),
    .in_src1_reg      (in_src1_reg),
    .in_src2_reg      (in_src2_reg),
    .in_raw_immediate (in_raw_immediate),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_write_enable (out_write_enable),
    .out_write_index  (out_write_index),
    .out_write_value  (out_write_value),
    .out_branch_taken (out_branch_taken),
    .out_next_pc      (out_next_pc)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Executes one instruction on the architectural state and returns its retire record.
  function automatic retire_t retire_insn(input mode_t m, input reg_idx_t rd,
                                          input reg_idx_t rs1, input reg_idx_t rs2,
                                          input logic [19:0] raw);
    logic [XLEN-1:0]        a, b, iimm, val, npc;
    logic signed [XLEN-1:0] sa;
    logic [20:0]            joff;
    logic [12:0]            boff;
    logic                   wr, tk, cond;
    retire_t                r;
    a    = (rs1 != '0 && int'(rs1) < REG_COUNT) ? arch_regs[rs1] : '0;
    b    = (rs2 != '0 && int'(rs2) < REG_COUNT) ? arch_regs[rs2] : '0;
    sa   = a;
    iimm = {{20{raw[11]}}, raw[11:0]};
    joff = {raw[19], raw[7:0], raw[8], raw[18:9], 1'b0};
    boff = {raw[6], rd[0], raw[5:0], rd[4:1], 1'b0};
    npc  = arch_pc + 32'd4;
    val  = '0;
    wr   = 1'b0;
    tk   = 1'b0;
    cond = 1'b0;
    case (m)
      MODE_LUI: begin
        val = {raw, 12'h000};
        wr  = 1'b1;
      end
      MODE_AUIPC: begin
        val = {raw, 12'h000} + arch_pc;
        wr  = 1'b1;
      end
      MODE_JAL: begin
        val = arch_pc + 32'd4;
        wr  = 1'b1;
        npc = arch_pc + {{11{joff[20]}}, joff};
        tk  = 1'b1;
      end
      MODE_JALR: begin
        val = arch_pc + 32'd4;
        wr  = 1'b1;
        npc = (a + iimm) & ~32'h1;
        tk  = 1'b1;
      end
      MODE_BEQ, MODE_BNE, MODE_BLT, MODE_BGE, MODE_BLTU, MODE_BGEU: begin
        case (m)
          MODE_BEQ:  cond = (a == b);
          MODE_BNE:  cond = (a != b);
          MODE_BLT:  cond = ($signed(a) < $signed(b));
          MODE_BGE:  cond = !($signed(a) < $signed(b));
          MODE_BLTU: cond = (a < b);
          default:   cond = (a >= b);
        endcase
        if (cond) begin
          npc = arch_pc + {{19{boff[12]}}, boff};
          tk  = 1'b1;
        end
      end
      MODE_ADDI:  begin val = a + iimm;                              wr = 1'b1; end
      MODE_SLTI:  begin val = {31'b0, $signed(a) < $signed(iimm)};   wr = 1'b1; end
      MODE_SLTIU: begin val = {31'b0, a < iimm};                     wr = 1'b1; end
      MODE_XORI:  begin val = a ^ iimm;                              wr = 1'b1; end
      MODE_ORI:   begin val = a | iimm;                              wr = 1'b1; end
      MODE_ANDI:  begin val = a & iimm;                              wr = 1'b1; end
      MODE_SLLI:  begin val = a << rs2;                              wr = 1'b1; end
      MODE_SRLI:  begin val = a >> rs2;                              wr = 1'b1; end
      MODE_SRAI:  begin val = sa >>> rs2;                            wr = 1'b1; end
      MODE_ADD:   begin val = a + b;                                 wr = 1'b1; end
      MODE_SUB:   begin val = a - b;                                 wr = 1'b1; end
      MODE_SLL:   begin val = a << b[4:0];                           wr = 1'b1; end
      MODE_SLT:   begin val = {31'b0, $signed(a) < $signed(b)};      wr = 1'b1; end
      MODE_SLTU:  begin val = {31'b0, a < b};                        wr = 1'b1; end
      MODE_XOR:   begin val = a ^ b;                                 wr = 1'b1; end
      MODE_SRL:   begin val = a >> b[4:0];                           wr = 1'b1; end
      MODE_SRA:   begin val = sa >>> b[4:0];                         wr = 1'b1; end
      MODE_OR:    begin val = a | b;                                 wr = 1'b1; end
      MODE_AND:   begin val = a & b;                                 wr = 1'b1; end
      default: ;  // unused modes only advance the pc
    endcase
    if (wr && (rd == '0 || int'(rd) >= REG_COUNT)) wr = 1'b0;
    if (wr) arch_regs[rd] = val;
    arch_pc = npc;
    r.we    = wr;
    r.idx   = wr ? rd : '0;
    r.val   = wr ? val : '0;
    r.taken = tk;
    r.npc   = npc;
    return r;
  endfunction

  // Drives one instruction, honoring the burst/gap pattern, and records its expected result.
  task automatic issue_insn(input mode_t m, input reg_idx_t rd, input reg_idx_t rs1,
                            input reg_idx_t rs2, input logic [19:0] raw);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (send_gaps && $urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid         <= 1'b1;
    in_mode          <= m;
    in_dest_reg      <= rd;
    in_src1_reg      <= rs1;
    in_src2_reg      <= rs2;
    in_raw_immediate <= raw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_retire.push_back(retire_insn(m, rd, rs1, rs2, raw));
    insns_issued++;
  endtask

  // Mostly a small register window, so back-to-back dependencies are frequent.
  function automatic reg_idx_t pick_reg();
    return ($urandom_range(0, 3) != 0) ? reg_idx_t'($urandom_range(0, 7))
                                       : reg_idx_t'($urandom_range(0, 31));
  endfunction

  task automatic random_insn(input bit noisy);
    mode_t       m;
    logic [19:0] raw;
    int          r;
    r   = $urandom_range(0, 99);
    raw = 20'($urandom());
    if (noisy)       m = mode_t'($urandom_range(0, 31));
    else if (r < 8)  m = mode_t'($urandom_range(MODE_LUI, MODE_AUIPC));
    else if (r < 14) m = mode_t'($urandom_range(MODE_JAL, MODE_JALR));
    else if (r < 34) m = mode_t'($urandom_range(MODE_BEQ, MODE_BGEU));
    else if (r < 60) m = mode_t'($urandom_range(MODE_ADDI, MODE_SRAI));
    else if (r < 97) m = mode_t'($urandom_range(MODE_ADD, MODE_AND));
    else             m = mode_t'($urandom_range(MODE_NOP, MODE_TOP));
    case ($urandom_range(0, 7))
      0: raw[11:0] = 12'h7ff;
      1: raw[11:0] = 12'h800;
      2: raw[11:0] = 12'hfff;
      3: raw[11:0] = 12'h000;
      default: ;
    endcase
    if (noisy)
      issue_insn(m, reg_idx_t'($urandom()), reg_idx_t'($urandom()),
                 reg_idx_t'($urandom()), raw);
    else
      issue_insn(m, pick_reg(), pick_reg(), pick_reg(), raw);
  endtask

  task automatic test_upper_and_jumps();
    issue_insn(MODE_LUI,   5'd2,  5'd0,  5'd0, 20'h80000);
    issue_insn(MODE_LUI,   5'd5,  5'd0,  5'd0, 20'hfffff);
    issue_insn(MODE_AUIPC, 5'd6,  5'd0,  5'd0, 20'hfffff);
    issue_insn(MODE_ADDI,  5'd1,  5'd0,  5'd0, 20'h00fff);
    issue_insn(MODE_ADDI,  5'd3,  5'd2,  5'd0, 20'h00fff);
    issue_insn(MODE_JAL,   5'd0,  5'd0,  5'd0, 20'h7ffff);  // rd = x0: no link
    issue_insn(MODE_JAL,   5'd7,  5'd0,  5'd0, 20'h80000);
    issue_insn(MODE_JALR,  5'd8,  5'd2,  5'd0, 20'hab7ff);  // odd target, junk upper bits
    issue_insn(MODE_JALR,  5'd3,  5'd3,  5'd0, 20'h00000);  // rs1 == rd
  endtask

  task automatic test_branches();
    issue_insn(MODE_BEQ,  5'h1f, 5'd0, 5'd0, 20'h0007f);
    issue_insn(MODE_BNE,  5'h1e, 5'd1, 5'd2, 20'hfffbf);
    issue_insn(MODE_BLT,  5'h01, 5'd2, 5'd3, 20'h00040);
    issue_insn(MODE_BGE,  5'h0a, 5'd2, 5'd3, 20'h00015);
    issue_insn(MODE_BLTU, 5'h10, 5'd3, 5'd1, 20'h00000);
    issue_insn(MODE_BGEU, 5'h0c, 5'd3, 5'd1, 20'h00033);
  endtask

  task automatic test_alu_edges();
    issue_insn(MODE_SLTI,  5'd9,  5'd2, 5'd0,  20'h007ff);
    issue_insn(MODE_SLTIU, 5'd10, 5'd1, 5'd0,  20'h00fff);
    issue_insn(MODE_SRAI,  5'd11, 5'd2, 5'd31, 20'h00000);
    issue_insn(MODE_SLLI,  5'd12, 5'd1, 5'd31, 20'h00000);
    issue_insn(MODE_SRL,   5'd13, 5'd1, 5'd3,  20'h00000);
    issue_insn(MODE_SUB,   5'd14, 5'd0, 5'd1,  20'h00000);
    issue_insn(MODE_SRA,   5'd15, 5'd2, 5'd1,  20'h00000);
    issue_insn(MODE_ADD,   5'd0,  5'd1, 5'd1,  20'h00000);  // write to x0 dropped
    issue_insn(MODE_XORI,  5'd16, 5'd1, 5'd0,  20'hff800);
    issue_insn(MODE_ORI,   5'd17, 5'd0, 5'd0,  20'h00800);
    issue_insn(MODE_ANDI,  5'd18, 5'd1, 5'd0,  20'h5a7ff);
    issue_insn(MODE_NOP,   5'd19, 5'd1, 5'd2,  20'hfffff);
    issue_insn(MODE_NOP + 5'd1, 5'd20, 5'd1, 5'd2, 20'h12345);
    issue_insn(MODE_TOP,   5'd21, 5'd1, 5'd2,  20'h00000);
  endtask

  task automatic test_random_program(input int n);
    send_gaps = 1'b1;
    stall_on  = 1'b1;
    repeat (n) random_insn(1'b0);
  endtask

  // No idling on either side: full-rate dependent chains.
  task automatic test_back_to_back(input int n);
    send_gaps = 1'b0;
    stall_on  = 1'b0;
    repeat (n) random_insn(1'b0);
  endtask

  task automatic test_random_noise(input int n);
    send_gaps = 1'b1;
    stall_on  = 1'b1;
    repeat (n) random_insn(1'b1);
  endtask

  // Receiver stall pattern: random runs of stall and release.
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_state = stall_on && ($urandom_range(0, 2) == 0);
      stall_run   = stall_state ? $urandom_range(1, 8) : $urandom_range(1, 10);
    end
    stall_run--;
    out_stall <= stall_state;
  end

  function automatic void check_field(input string name, input logic [XLEN-1:0] exp_v,
                                      input logic [XLEN-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    retire_t exp_r;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_retire.size() == 0) begin
          $error("result with no instruction outstanding: next_pc 0x%08h", out_next_pc);
          mismatch_count++;
        end else begin
          exp_r = expected_retire.pop_front();
          check_field("write_enable", 32'(exp_r.we), 32'(out_write_enable));
          check_field("write_index", 32'(exp_r.idx), 32'(out_write_index));
          check_field("write_value", exp_r.val, out_write_value);
          check_field("branch_taken", 32'(exp_r.taken), 32'(out_branch_taken));
          check_field("next_pc", exp_r.npc, out_next_pc);
          results_checked++;
          if (exp_r.taken) taken_count++;
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_mode          = MODE_LUI;
    in_dest_reg      = '0;
    in_src1_reg      = '0;
    in_src2_reg      = '0;
    in_raw_immediate = '0;
    out_stall        = 1'b0;
    stall_state      = 1'b0;
    stall_run        = 0;
    stall_on         = 1'b1;
    send_gaps        = 1'b1;
    burst_left       = 0;
    idle_cycles      = 0;
    mismatch_count   = 0;
    insns_issued     = 0;
    results_checked  = 0;
    taken_count      = 0;
    arch_pc          = '0;
    for (int i = 0; i < REG_COUNT; i++) arch_regs[i] = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_upper_and_jumps();
    test_branches();
    test_alu_edges();
    test_random_program(600);
    test_back_to_back(100);
    test_random_noise(100);

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_retire.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d instructions issued, %0d results checked, %0d control transfers taken",
             insns_issued, results_checked, taken_count);
    $display("all modes incl. unused ones, x0 targets, jump/branch offset extremes, %s",
             "random stalls and full-rate dependent chains");
    if (mismatch_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
